>>> hw/rtl/glyph_rle_pixel_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glyph RLE pixel decoder
// Shorthand for clocked implications, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef GLYPH_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define GLYPH_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/grd_pkg.sv
// ----------------------------------------------------------------------------
// grd_pkg
// Types, codes and helpers shared by the glyph RLE pixel decoder modules.
// ----------------------------------------------------------------------------
package grd_pkg;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
    } code_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       last_of_run;
    } pixel_t;

    // Literal progress.
    localparam logic [1:0] LIT_NONE = 2'd0;
    localparam logic [1:0] LIT_HIGH = 2'd1;
    localparam logic [1:0] LIT_LOW  = 2'd2;

    // Top two bits of a code byte.
    localparam logic [1:0] FLAG_RUN_CLEAR = 2'b00;
    localparam logic [1:0] FLAG_RUN_SOLID = 2'b01;
    localparam logic [1:0] FLAG_SPLIT     = 2'b10;
    localparam logic [1:0] FLAG_PAIR      = 2'b11;

    localparam logic [11:0] BASE_RGB_RESET = 12'hFFF;
    localparam logic [3:0]  ALPHA_CLEAR    = 4'h0;
    localparam logic [3:0]  ALPHA_SOLID    = 4'hF;
    localparam logic [2:0]  SPLIT_RUN_MAX  = 3'd5;

    typedef struct packed {
        logic load;   // take the offered code byte
        logic step;   // move the next pixel into the output register
    } grd_cmd_t;

    typedef struct packed {
        logic has_pixels;  // the offered byte produces at least one pixel
        logic slot_free;   // the output register can take a pixel this cycle
        logic final_pixel; // the pixel about to be stepped out is the last one
    } grd_status_t;

    // Three-bit alpha to a nibble.
    function automatic logic [3:0] widen3(input logic [2:0] t);
        return {t, t[0]};
    endfunction

    // Nibble to eight bits, n * 17.
    function automatic logic [7:0] widen4(input logic [3:0] n);
        return {n, n};
    endfunction

endpackage

>>> hw/rtl/grd_ctrl.sv
// ----------------------------------------------------------------------------
// grd_ctrl
// Controller: accepts code bytes and sequences pixel output one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module grd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 code_valid,
    output logic                 code_stall,
    input  grd_pkg::grd_status_t status,
    output grd_pkg::grd_cmd_t    cmd
);
    import grd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        code_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                code_stall = 1'b0;
                if (code_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.has_pixels)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.step = 1'b1;
                    if (status.final_pixel)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/grd_datapath.sv
// ----------------------------------------------------------------------------
// grd_datapath
// Byte decoder, colour and literal state, pixel counters and output register.
// ----------------------------------------------------------------------------
module grd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  grd_pkg::code_t       code,
    input  logic                 pixel_stall,
    output logic                 pixel_valid,
    output grd_pkg::pixel_t      pixel,
    input  grd_pkg::grd_cmd_t    cmd,
    output grd_pkg::grd_status_t status
);
    import grd_pkg::*;

    logic [11:0] base_rgb_reg, base_rgb_next;
    logic [1:0]  lit_phase_reg, lit_phase_next;
    logic [7:0]  lit_high_reg, lit_high_next;
    logic [11:0] pix_rgb_reg;
    logic [3:0]  alpha1_reg, alpha2_reg;
    logic [5:0]  cnt1_reg;
    logic [2:0]  cnt2_reg;
    logic        pix_valid_reg;
    pixel_t      pix_reg;

    logic [5:0]  dec_cnt1;
    logic [2:0]  dec_cnt2;
    logic [3:0]  dec_a1, dec_a2;
    logic [11:0] dec_rgb;
    logic [1:0]  flags;
    logic [2:0]  tail;
    logic        final_pixel;
    logic [3:0]  step_alpha;

    assign flags = code.code_byte[7:6];
    assign tail  = code.code_byte[2:0];

    always_comb
    begin
        dec_cnt1       = '0;
        dec_cnt2       = '0;
        dec_a1         = ALPHA_CLEAR;
        dec_a2         = ALPHA_CLEAR;
        dec_rgb        = base_rgb_reg;
        base_rgb_next  = base_rgb_reg;
        lit_phase_next = lit_phase_reg;
        lit_high_next  = lit_high_reg;
        case (lit_phase_reg)
            LIT_HIGH:
            begin
                lit_high_next  = code.code_byte;
                lit_phase_next = LIT_LOW;
            end
            LIT_LOW:
            begin
                dec_cnt1       = 6'd1;
                dec_a1         = lit_high_reg[7:4];
                dec_rgb        = {lit_high_reg[3:0], code.code_byte};
                base_rgb_next  = {lit_high_reg[3:0], code.code_byte};
                lit_phase_next = LIT_NONE;
            end
            default:
            begin
                if (code.code_byte == 8'd0)
                begin
                    lit_phase_next = LIT_HIGH;
                end
                else
                begin
                    case (flags)
                        FLAG_RUN_CLEAR:
                        begin
                            dec_cnt1 = code.code_byte[5:0];
                        end
                        FLAG_RUN_SOLID:
                        begin
                            dec_cnt1 = code.code_byte[5:0];
                            dec_a1   = ALPHA_SOLID;
                        end
                        FLAG_PAIR:
                        begin
                            dec_cnt1 = 6'd1;
                            dec_a1   = widen3(code.code_byte[5:3]);
                            dec_cnt2 = 3'd1;
                            dec_a2   = widen3(tail);
                        end
                        default:
                        begin
                            // Split code: one coded-alpha pixel, then a short run unless the tail bits are zero.
                            dec_cnt1 = 6'd1;
                            dec_a1   = widen3(code.code_byte[5:3]);
                            if (tail != 3'd0)
                            begin
                                dec_cnt2 = SPLIT_RUN_MAX - {1'b0, tail[1:0]};
                                dec_a2   = tail[2] ? ALPHA_CLEAR : ALPHA_SOLID;
                            end
                        end
                    endcase
                end
            end
        endcase
        // The last byte of a glyph drops any pending literal and restores the base.
        if (code.last_byte)
        begin
            base_rgb_next  = BASE_RGB_RESET;
            lit_phase_next = LIT_NONE;
            lit_high_next  = 8'd0;
        end
    end

    assign final_pixel = ((cnt1_reg == 6'd1) && (cnt2_reg == 3'd0)) ||
                         ((cnt1_reg == 6'd0) && (cnt2_reg == 3'd1));
    assign step_alpha  = (cnt1_reg != 6'd0) ? alpha1_reg : alpha2_reg;

    assign status.has_pixels  = (dec_cnt1 != 6'd0) || (dec_cnt2 != 3'd0);
    assign status.slot_free   = !pix_valid_reg || !pixel_stall;
    assign status.final_pixel = final_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_rgb_reg  <= BASE_RGB_RESET;
            lit_phase_reg <= LIT_NONE;
            lit_high_reg  <= 8'd0;
            cnt1_reg      <= '0;
            cnt2_reg      <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                base_rgb_reg  <= base_rgb_next;
                lit_phase_reg <= lit_phase_next;
                lit_high_reg  <= lit_high_next;
                cnt1_reg      <= dec_cnt1;
                cnt2_reg      <= dec_cnt2;
            end
            else if (cmd.step)
            begin
                if (cnt1_reg != 6'd0)
                begin
                    cnt1_reg <= cnt1_reg - 6'd1;
                end
                else
                begin
                    cnt2_reg <= cnt2_reg - 3'd1;
                end
            end
            if (cmd.step)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (!pixel_stall)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_rgb_reg <= dec_rgb;
            alpha1_reg  <= dec_a1;
            alpha2_reg  <= dec_a2;
        end
        if (cmd.step)
        begin
            pix_reg.blue        <= widen4(pix_rgb_reg[3:0]);
            pix_reg.green       <= widen4(pix_rgb_reg[7:4]);
            pix_reg.red         <= widen4(pix_rgb_reg[11:8]);
            pix_reg.alpha       <= widen4(step_alpha);
            pix_reg.last_of_run <= final_pixel;
        end
    end

    assign pixel_valid = pix_valid_reg;
    assign pixel       = pix_reg;

endmodule

>>> hw/rtl/glyph_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// glyph_rle_pixel_decoder_core
// Run-length glyph decoder: code bytes in, BGRA pixels out.
// ----------------------------------------------------------------------------
// A code byte is accepted in ST_IDLE and its pixels are then stepped out in
// ST_EMIT, N of them with N from 0 to 63. Bytes that produce no pixel, such
// as the opening and high bytes of a literal or an empty run, leave the
// controller in ST_IDLE; the low byte of a literal produces one pixel. The
// pixel counter hands one pixel per cycle to the output register while that
// register is not stalled. The code channel stalls while a byte's pixels are
// still being sent; a finished pixel may wait in the output register while
// the next byte is taken.
module glyph_rle_pixel_decoder_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            code_valid,
    output logic            code_stall,
    input  grd_pkg::code_t  code,
    output logic            pixel_valid,
    input  logic            pixel_stall,
    output grd_pkg::pixel_t pixel
);
    import grd_pkg::*;

    grd_cmd_t    cmd;
    grd_status_t status;

    grd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .status     (status),
        .cmd        (cmd)
    );

    grd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .code        (code),
        .pixel_stall (pixel_stall),
        .pixel_valid (pixel_valid),
        .pixel       (pixel),
        .cmd         (cmd),
        .status      (status)
    );

`include "glyph_rle_pixel_decoder_core_assert.svh"

    // A byte that produces pixels blocks further bytes until they are sent.
    `GRD_ASSERT_NEXT(a_busy_after_run, code_valid && !code_stall && status.has_pixels, code_stall, "code accepted while pixels pending")

    // Pixels of one byte leave back to back: a non-final transaction is refilled.
    `GRD_ASSERT_NEXT(a_run_continues, pixel_valid && !pixel_stall && !pixel.last_of_run, pixel_valid, "pixel run broken before its last pixel")

    // A pixel is only stepped out while no byte is being taken.
    `GRD_ASSERT_SAME(a_load_or_step, cmd.step, !cmd.load && code_stall, "pixel stepped while code channel open")

endmodule
